[rtl/core/hsv_pkg.sv]
// Package for the half sphere vertex generator: constants, types, CORDIC table.
// No dependencies.
package hsv_pkg;

  localparam int MAX_SECTORS_DEF = 1024;
  localparam int MAX_STACKS_DEF  = 1024;
  localparam int CORDIC_STEPS    = 15;
  localparam int CW              = 34;   // CORDIC datapath width
  localparam logic signed [CW-1:0] CORDIC_START = 34'sd652032874;

  // Register byte addresses
  localparam logic [3:0] ADDR_RADIUS = 4'd0;
  localparam logic [3:0] ADDR_SECTOR = 4'd4;
  localparam logic [3:0] ADDR_STACK  = 4'd8;

  typedef enum logic [2:0] {
    ST_IDLE, ST_DIV, ST_CORDIC, ST_MUL1, ST_MUL2, ST_OUT
  } state_t;

  // data carried from one CORDIC cell to the next
  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [17:0]   z;
    logic                 flip;
  } cordic_t;

  function automatic logic signed [17:0] atan_turn(input int i);
    logic signed [17:0] r;
    begin
      unique case (i)
        0: r = 18'sd8192;  1: r = 18'sd4836; 2: r = 18'sd2555; 3: r = 18'sd1297;
        4: r = 18'sd651;   5: r = 18'sd326;  6: r = 18'sd163;  7: r = 18'sd81;
        8: r = 18'sd41;    9: r = 18'sd20;   10: r = 18'sd10;  11: r = 18'sd5;
        12: r = 18'sd3;    default: r = 18'sd1;
      endcase
      return r;
    end
  endfunction

  // round to Q1.15 with saturation
  function automatic logic signed [16:0] to_q15(input logic signed [CW-1:0] v);
    logic signed [CW-1:0] t;
    logic signed [CW-16:0] s;
    begin
      t = v + 34'sd16384;
      s = t[CW-1:15];
      if (s > 19'sd32767) return 17'sd32767;
      else if (s < -19'sd32768) return -17'sd32768;
      else return s[16:0];
    end
  endfunction

endpackage

[rtl/core/hsv_cordic_cell.sv]
// One CORDIC rotation cell; fixed iteration index I.
// Depends on hsv_pkg.
module hsv_cordic_cell #(
  parameter int I = 0
) (
  input  logic             clk,
  input  hsv_pkg::cordic_t d_in,
  output hsv_pkg::cordic_t d_out_r
);
  import hsv_pkg::*;

  cordic_t d_nxt;
  logic signed [CW-1:0] dx, dy;

  // one micro-rotation toward z = 0
  always_comb begin
    dx = d_in.y >>> I;
    dy = d_in.x >>> I;
    d_nxt = d_in;
    if (!d_in.z[17]) begin
      d_nxt.x = d_in.x - dx;
      d_nxt.y = d_in.y + dy;
      d_nxt.z = d_in.z - atan_turn(I);
    end else begin
      d_nxt.x = d_in.x + dx;
      d_nxt.y = d_in.y - dy;
      d_nxt.z = d_in.z + atan_turn(I);
    end
  end

  always_ff @(posedge clk) begin
    d_out_r <= d_nxt;
  end
endmodule

[rtl/core/hsv_cordic_chain.sv]
// Chain of CORDIC cells: angle in through a head register, rounded Q1.15 sine and
// cosine out after one register per cell. Depends on hsv_pkg and hsv_cordic_cell.
module hsv_cordic_chain (
  input  logic               clk,
  input  logic [15:0]        turn,
  output logic signed [16:0] sin_q,
  output logic signed [16:0] cos_q
);
  import hsv_pkg::*;

  cordic_t stage [CORDIC_STEPS+1];
  cordic_t head_nxt;
  logic [15:0] a;

  // quadrant fold into [-pi/2, pi/2)
  always_comb begin
    a = turn;
    head_nxt.flip = 1'b0;
    if (turn >= 16'h4000 && turn < 16'hC000) begin
      a = turn - 16'h8000;
      head_nxt.flip = 1'b1;
    end
    head_nxt.x = CORDIC_START;
    head_nxt.y = '0;
    head_nxt.z = {{2{a[15]}}, a};
  end

  always_ff @(posedge clk) begin
    stage[0] <= head_nxt;
  end

  for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_cell
    hsv_cordic_cell #(.I(g)) u_cell (
      .clk    (clk),
      .d_in   (stage[g]),
      .d_out_r(stage[g+1])
    );
  end

  always_comb begin
    if (stage[CORDIC_STEPS].flip) begin
      cos_q = to_q15(-stage[CORDIC_STEPS].x);
      sin_q = to_q15(-stage[CORDIC_STEPS].y);
    end else begin
      cos_q = to_q15(stage[CORDIC_STEPS].x);
      sin_q = to_q15(stage[CORDIC_STEPS].y);
    end
  end
endmodule

[rtl/core/hsv_divider.sv]
// Restoring divider, one quotient bit per cycle: q = num / den.
// No dependencies.
module hsv_divider #(
  parameter int NW = 28,
  parameter int DW = 13
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic          done_r,
  output logic [NW-1:0] quo_r
);

  localparam int CNTW = $clog2(NW + 1);

  logic [DW:0]     rem_r, rem_nxt, trial;
  logic [NW-1:0]   quo_nxt;
  logic [DW-1:0]   den_r;
  logic [CNTW-1:0] cnt_r, cnt_nxt;
  logic            done_nxt;

  always_comb begin
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    cnt_nxt  = cnt_r;
    done_nxt = 1'b0;
    trial    = {rem_r[DW-1:0], quo_r[NW-1]};
    if (start) begin
      rem_nxt = '0;
      quo_nxt = num;
      cnt_nxt = CNTW'(NW);
    end else if (cnt_r != '0) begin
      if (trial >= {1'b0, den_r}) begin
        rem_nxt = trial - {1'b0, den_r};
        quo_nxt = {quo_r[NW-2:0], 1'b1};
      end else begin
        rem_nxt = trial;
        quo_nxt = {quo_r[NW-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      done_nxt = (cnt_r == CNTW'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      done_r <= done_nxt;
    end
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    if (start) den_r <= den;
  end
endmodule

[rtl/core/half_sphere_vertex_generator_top.sv]
// Channel  | direction | payload
// in_      | input     | restart
// out_     | output    | pos_x, pos_y, pos_z, ring_index, around_index, last
// cfg_     | APB       | radius (0x0), sector_count (0x4), stack_count (0x8)
// One vertex at a time: the two angle divisions run in sequence on one bit-serial
// divider (phi, then theta), then both angles pass through the CORDIC cell chain,
// then the multiply states ST_MUL1 and ST_MUL2 and the output state ST_OUT. A new
// input transfer is taken only once the sequencer is back in ST_IDLE, so items do
// not overlap in the sequencer. Reset is synchronous, active low.
// The result waits in an output register; out_stall holds it, and in_stall is
// high whenever an item is in flight. A new item only waits at the output step.
// Depends on hsv_pkg, hsv_divider, hsv_cordic_chain, hsv_cordic_cell.
module half_sphere_vertex_generator_top #(
  parameter int MAX_SECTORS = hsv_pkg::MAX_SECTORS_DEF,
  parameter int MAX_STACKS  = hsv_pkg::MAX_STACKS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               in_restart,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [16:0] out_pos_x,
  output logic signed [16:0] out_pos_y,
  output logic signed [16:0] out_pos_z,
  output logic [9:0]         out_ring_index,
  output logic [10:0]        out_around_index,
  output logic               out_last,
  input  logic               cfg_psel,
  input  logic               cfg_penable,
  input  logic               cfg_pwrite,
  input  logic [3:0]         cfg_paddr,
  input  logic [31:0]        cfg_pwdata,
  output logic [31:0]        cfg_prdata,
  output logic               cfg_pready
);
  import hsv_pkg::*;

  localparam int SPW = 13; // holds counts up to 8191
  localparam int NW  = 17 + SPW;
  localparam int CWT = $clog2(CORDIC_STEPS + 3);

  logic [15:0] radius_r;
  logic [10:0] sector_count_r, stack_count_r;
  logic [SPW-1:0] stack_pos_r, stack_pos_nxt, sector_pos_r, sector_pos_nxt;
  logic started_r;
  state_t state_r, state_nxt;
  logic phase_r, phase_nxt;          // 0: phi division, 1: theta division
  logic [CWT-1:0] wait_r, wait_nxt;
  logic [15:0] phi_r, theta_r;
  logic [SPW-1:0] nsec, nstk, half;
  logic cfg_wr, in_acc, out_acc, out_load;

  // configuration port
  assign cfg_pready = 1'b1;
  assign cfg_wr = cfg_psel && cfg_penable && cfg_pwrite;
  always_comb begin
    unique case (cfg_paddr)
      ADDR_RADIUS: cfg_prdata = {16'd0, radius_r};
      ADDR_SECTOR: cfg_prdata = {21'd0, sector_count_r};
      ADDR_STACK:  cfg_prdata = {21'd0, stack_count_r};
      default:     cfg_prdata = '0;
    endcase
  end

  // clamped counts
  always_comb begin
    if (sector_count_r == '0) nsec = SPW'(1);
    else if ({2'b0, sector_count_r} > SPW'(MAX_SECTORS)) nsec = SPW'(MAX_SECTORS);
    else nsec = {2'b0, sector_count_r};
    if (stack_count_r == '0) nstk = SPW'(1);
    else if ({2'b0, stack_count_r} > SPW'(MAX_STACKS)) nstk = SPW'(MAX_STACKS);
    else nstk = {2'b0, stack_count_r};
    half = nstk >> 1;
  end

  assign in_acc  = in_valid && !in_stall;
  assign out_acc = out_valid && !out_stall;
  assign in_stall = (state_r != ST_IDLE);

  // counter advance
  always_comb begin
    stack_pos_nxt  = stack_pos_r;
    sector_pos_nxt = sector_pos_r;
    if (!started_r || in_restart || stack_pos_r > half) begin
      stack_pos_nxt = '0; sector_pos_nxt = '0;
    end else if (sector_pos_r < nsec) begin
      sector_pos_nxt = sector_pos_r + 1'b1;
    end else if (stack_pos_r < half) begin
      stack_pos_nxt = stack_pos_r + 1'b1; sector_pos_nxt = '0;
    end else begin
      stack_pos_nxt = '0; sector_pos_nxt = '0;
    end
  end

  // divider: phi starts on the input transfer with the advanced ring,
  // theta starts when phi is done
  logic div_start, div_done;
  logic [NW-1:0] div_num, div_quo;
  logic [SPW-1:0] div_den;
  always_comb begin
    if (state_r == ST_IDLE) begin
      div_num = NW'({stack_pos_nxt, 15'd0}) + NW'(nstk >> 1);
      div_den = nstk;
    end else begin
      div_num = NW'({sector_pos_r, 16'd0}) + NW'(nsec >> 1);
      div_den = nsec;
    end
  end
  hsv_divider #(.NW(NW), .DW(SPW)) u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .num(div_num), .den(div_den),
    .done_r(div_done), .quo_r(div_quo)
  );

  // CORDIC chain, shared by both angles; theta enters in the cycle after phi
  logic [15:0] cordic_turn;
  logic signed [16:0] sin_q, cos_q, sphi_r, cphi_r, sth_r, cth_r;
  hsv_cordic_chain u_cordic (.clk(clk), .turn(cordic_turn), .sin_q(sin_q), .cos_q(cos_q));

  // multiply stages
  logic signed [33:0] rc_r, rs_r;
  logic signed [50:0] px_full, py_full;
  logic signed [16:0] px_r, py_r, pz_r;
  logic last_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    phase_nxt = phase_r;
    wait_nxt  = wait_r;
    unique case (state_r)
      ST_IDLE:   if (in_acc) begin state_nxt = ST_DIV; phase_nxt = 1'b0; end
      ST_DIV:    if (div_done) begin
                   if (phase_r) begin state_nxt = ST_CORDIC; wait_nxt = '0; end
                   else phase_nxt = 1'b1;
                 end
      ST_CORDIC: begin
                   wait_nxt = wait_r + 1'b1;
                   if (wait_r == CWT'(CORDIC_STEPS + 1)) state_nxt = ST_MUL1;
                 end
      ST_MUL1:   state_nxt = ST_MUL2;
      ST_MUL2:   state_nxt = ST_OUT;
      ST_OUT:    if (out_load) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    div_start = ((state_r == ST_IDLE) && in_acc) ||
                ((state_r == ST_DIV) && div_done && !phase_r);
    cordic_turn = (state_r == ST_CORDIC && wait_r == '0) ? phi_r : theta_r;
    out_load = (state_r == ST_OUT) && (!out_valid || !out_stall);
  end

  assign px_full = rc_r * cth_r;
  assign py_full = rc_r * sth_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE; phase_r <= 1'b0; wait_r <= '0;
      radius_r <= 16'd1000; sector_count_r <= 11'd36; stack_count_r <= 11'd18;
      stack_pos_r <= '0; sector_pos_r <= '0; started_r <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state_r <= state_nxt; phase_r <= phase_nxt; wait_r <= wait_nxt;
      if (cfg_wr) begin
        unique case (cfg_paddr)
          ADDR_RADIUS: radius_r <= cfg_pwdata[15:0];
          ADDR_SECTOR: sector_count_r <= cfg_pwdata[10:0];
          ADDR_STACK:  stack_count_r <= cfg_pwdata[10:0];
          default: ;
        endcase
      end
      if (in_acc) begin
        stack_pos_r <= stack_pos_nxt; sector_pos_r <= sector_pos_nxt;
        started_r <= 1'b1;
      end
      if (out_load) out_valid <= 1'b1;
      else if (out_acc) out_valid <= 1'b0;
    end
    // angle registers
    if (state_r == ST_DIV && div_done) begin
      if (!phase_r) phi_r <= 16'h4000 - div_quo[15:0];
      else theta_r <= div_quo[15:0];
    end
    // phi result leaves the chain in the cycle before theta
    if (state_r == ST_CORDIC && wait_r == CWT'(CORDIC_STEPS + 1)) begin
      sphi_r <= sin_q; cphi_r <= cos_q;
    end
    if (state_r == ST_MUL1) begin
      sth_r <= sin_q; cth_r <= cos_q;
      rc_r <= $signed({1'b0, radius_r}) * cphi_r;
      rs_r <= $signed({1'b0, radius_r}) * sphi_r;
      last_r <= (stack_pos_r == half) && (sector_pos_r == nsec);
    end
    if (state_r == ST_MUL2) begin
      px_r <= 17'((px_full + 51'sd536870912) >>> 30);
      py_r <= 17'((py_full + 51'sd536870912) >>> 30);
      pz_r <= 17'((rs_r + 34'sd16384) >>> 15);
    end
    if (out_load) begin
      out_pos_x <= px_r; out_pos_y <= py_r; out_pos_z <= pz_r;
      out_ring_index <= stack_pos_r[9:0];
      out_around_index <= sector_pos_r[10:0];
      out_last <= last_r;
    end
  end

  // assertions
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_IDLE) |-> !in_acc) else $error("accept while busy");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> out_valid) else $error("result dropped");
  a_idle_after_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |=> (out_valid && state_r == ST_IDLE)) else $error("out seq");
endmodule

[verif/tb_half_sphere_vertex_generator_top.sv]
// Testbench for half_sphere_vertex_generator_top: drives restart transfers and APB
// register writes, predicts every vertex in-line and checks each output transfer.
// Depends on hsv_pkg and the RTL of the generator.
`timescale 1ns / 100ps

module tb_half_sphere_vertex_generator_top;
  import hsv_pkg::*;

  localparam int MAX_SECT = 1024;
  localparam int MAX_STK  = 1024;
  localparam int IDLE_LIMIT = 20000;
  localparam int SETTLE_CYCLES = 120;
  localparam logic [3:0] ADDR_UNUSED = 4'd12;

  typedef struct packed {
    logic [16:0] x;
    logic [16:0] y;
    logic [16:0] z;
    logic [9:0]  ring;
    logic [10:0] around;
    logic        last;
  } vertex_t;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  logic               in_restart;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic signed [16:0] out_pos_x;
  logic signed [16:0] out_pos_y;
  logic signed [16:0] out_pos_z;
  logic [9:0]         out_ring_index;
  logic [10:0]        out_around_index;
  logic               out_last;
  logic               cfg_psel;
  logic               cfg_penable;
  logic               cfg_pwrite;
  logic [3:0]         cfg_paddr;
  logic [31:0]        cfg_pwdata;
  logic [31:0]        cfg_prdata;
  logic               cfg_pready;

  // predictor copy of registers and walk state
  int unsigned radius_q;
  int unsigned sectors_q;
  int unsigned stacks_q;
  int unsigned ring_q;
  int unsigned around_q;
  bit          walking_q;

  vertex_t expected_vertices[$];
  int      mismatches;
  int      send_idle_pct;
  int      recv_idle_pct;
  int      idle_cycles;
  bit      cfg_done;

  half_sphere_vertex_generator_top i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_restart(in_restart),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_pos_x(out_pos_x), .out_pos_y(out_pos_y), .out_pos_z(out_pos_z),
    .out_ring_index(out_ring_index), .out_around_index(out_around_index),
    .out_last(out_last),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // sine and cosine of a turn fraction by 15-step rotation, rounded to Q1.15
  function automatic void turn_sin_cos(input int unsigned turn, output longint s,
                                       output longint c);
    longint atan_tab[15] = '{8192, 4836, 2555, 1297, 651, 326, 163, 81, 41, 20,
                             10, 5, 3, 1, 1};
    int unsigned a;
    bit     flip;
    longint x, y, z, dx, dy;
    a = turn & 32'hFFFF;
    flip = 1'b0;
    x = 652032874;
    y = 0;
    if (a >= 32'h4000 && a < 32'hC000) begin
      a = (a - 32'h8000) & 32'hFFFF;
      flip = 1'b1;
    end
    z = (a >= 32'h8000) ? longint'(a) - 65536 : longint'(a);
    for (int i = 0; i < 15; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= atan_tab[i];
      end else begin
        x += dx; y -= dy; z += atan_tab[i];
      end
    end
    if (flip) begin
      x = -x;
      y = -y;
    end
    c = (x + 16384) >>> 15;
    s = (y + 16384) >>> 15;
    if (c > 32767) c = 32767;
    if (c < -32768) c = -32768;
    if (s > 32767) s = 32767;
    if (s < -32768) s = -32768;
  endfunction

  // advance the walk and compute the next vertex
  function automatic vertex_t next_vertex(input bit restart);
    int unsigned nsec, nstk, half, phi, theta;
    longint sphi, cphi, sth, cth, r;
    vertex_t v;
    nsec = (sectors_q == 0) ? 1 : (sectors_q > MAX_SECT ? MAX_SECT : sectors_q);
    nstk = (stacks_q == 0) ? 1 : (stacks_q > MAX_STK ? MAX_STK : stacks_q);
    half = nstk / 2;
    if (!walking_q || restart || ring_q > half) begin
      ring_q = 0;
      around_q = 0;
    end else if (around_q < nsec) begin
      around_q++;
    end else if (ring_q < half) begin
      ring_q++;
      around_q = 0;
    end else begin
      ring_q = 0;
      around_q = 0;
    end
    walking_q = 1'b1;
    phi = (16384 - (ring_q * 32768 + nstk / 2) / nstk) & 32'hFFFF;
    theta = ((around_q * 65536 + nsec / 2) / nsec) & 32'hFFFF;
    turn_sin_cos(phi, sphi, cphi);
    turn_sin_cos(theta, sth, cth);
    r = longint'(radius_q);
    v.x = 17'((r * cphi * cth + (64'sd1 <<< 29)) >>> 30);
    v.y = 17'((r * cphi * sth + (64'sd1 <<< 29)) >>> 30);
    v.z = 17'((r * sphi + 16384) >>> 15);
    v.ring = 10'(ring_q);
    v.around = 11'(around_q);
    v.last = (ring_q == half && around_q == nsec);
    return v;
  endfunction

  // result receiver stall
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  // compare each output transfer with the oldest prediction
  always @(posedge clk) begin
    vertex_t got, exp_v;
    if (rst_n && out_valid && !out_stall) begin
      got = '{out_pos_x, out_pos_y, out_pos_z, out_ring_index, out_around_index,
              out_last};
      if (expected_vertices.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("ERROR: unexpected vertex %p", got);
      end else begin
        exp_v = expected_vertices.pop_front();
        if (got !== exp_v) begin
          mismatches++;
          if (mismatches <= 10) $display("ERROR: vertex mismatch exp %p got %p", exp_v, got);
        end
      end
    end
  end

  // watchdog: cycles with no transfer of any kind
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_done) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("half_sphere_vertex_generator_top test failed");
        $finish;
      end
    end
  end

  // one restart/advance transfer; valid stays high unless the sender idles
  task automatic send_step(input bit restart);
    vertex_t v;
    in_valid <= 1'b1;
    in_restart <= restart;
    do @(posedge clk); while (in_stall);
    v = next_vertex(restart);
    expected_vertices = {expected_vertices, v};
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
  endtask

  // stop sending and wait until every vertex has come back
  task automatic drain_vertices();
    in_valid <= 1'b0;
    while (expected_vertices.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [3:0] addr, input int unsigned value);
    cfg_psel <= 1'b1;
    cfg_pwrite <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_paddr <= addr;
    cfg_pwdata <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    cfg_done <= 1'b1;
    @(posedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_done <= 1'b0;
    case (addr)
      ADDR_RADIUS: radius_q = value & 32'hFFFF;
      ADDR_SECTOR: sectors_q = value & 32'h7FF;
      ADDR_STACK:  stacks_q = value & 32'h7FF;
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic set_shape(input int unsigned r, input int unsigned n, input int unsigned s);
    write_reg(ADDR_RADIUS, r);
    write_reg(ADDR_SECTOR, n);
    write_reg(ADDR_STACK, s);
  endtask

  // reset defaults, first step after reset without restart, restart itself
  task automatic test_defaults();
    send_step(1'b0);
    repeat (3) send_step(1'b0);
    send_step(1'b1);
    send_step(1'b0);
    drain_vertices();
  endtask

  // extreme radii and counts, including zero and above-max counts
  task automatic test_extremes();
    set_shape(65535, 0, 0);
    repeat (3) send_step(1'b0);
    drain_vertices();
    set_shape(0, 2047, 2047);
    send_step(1'b1);
    send_step(1'b0);
    drain_vertices();
    set_shape(65535, 1024, 1024);
    send_step(1'b1);
    repeat (2) send_step(1'b0);
    drain_vertices();
    set_shape(65535, 1, 1);
    send_step(1'b1);
    repeat (3) send_step(1'b0);
    drain_vertices();
    write_reg(ADDR_UNUSED, 32'hFFFF_FFFF);
    set_shape(65535, 3, 2);
    send_step(1'b1);
    repeat (3) send_step(1'b0);
    drain_vertices();
  endtask

  // counts shrink under a walk in progress
  task automatic test_shrink_mid_walk();
    set_shape(1234, 4, 8);
    send_step(1'b1);
    repeat (16) send_step(1'b0);
    drain_vertices();
    write_reg(ADDR_STACK, 4);
    repeat (2) send_step(1'b0);
    drain_vertices();
    write_reg(ADDR_SECTOR, 8);
    send_step(1'b1);
    repeat (6) send_step(1'b0);
    drain_vertices();
    write_reg(ADDR_SECTOR, 4);
    repeat (2) send_step(1'b0);
    drain_vertices();
  endtask

  // random walks with occasional restarts and reconfiguration between bursts
  task automatic test_random_walks(input int items);
    int done;
    done = 0;
    while (done < items) begin
      if ($urandom_range(3) == 0)
        set_shape($urandom, $urandom_range(0, 2047), $urandom_range(0, 2047));
      else
        set_shape($urandom, $urandom_range(1, 12), $urandom_range(1, 12));
      repeat ($urandom_range(20, 60)) begin
        send_step($urandom_range(19) == 0);
        done++;
      end
      drain_vertices();
    end
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_restart = 1'b0;
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
    cfg_paddr = '0;
    cfg_pwdata = '0;
    cfg_done = 1'b0;
    mismatches = 0;
    idle_cycles = 0;
    send_idle_pct = 22;
    recv_idle_pct = 87;
    radius_q = 1000;
    sectors_q = 36;
    stacks_q = 18;
    ring_q = 0;
    around_q = 0;
    walking_q = 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_defaults();
    test_extremes();
    test_shrink_mid_walk();
    test_random_walks(250);
    send_idle_pct = 87;
    recv_idle_pct = 22;
    test_random_walks(250);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_walks(250);

    drain_vertices();
    if (mismatches == 0) begin
      $display("half_sphere_vertex_generator_top test passed");
    end else begin
      $display("half_sphere_vertex_generator_top test failed");
    end
    $finish;
  end

endmodule
